>>> rtl/hisc_pkg.sv
package hisc_pkg;

  localparam int CountW         = 33;
  localparam int VcountW        = 6;
  localparam int EdgeIdxW       = 6;
  localparam int VertIdxW       = 5;
  localparam int DefMaxVertices = 32;
  localparam int DefMaxEdges    = 64;

  localparam logic [VcountW-1:0] VcountReset = 6'd32;

  localparam logic CmdAdd   = 1'b0;
  localparam logic CmdCount = 1'b1;

endpackage

>>> rtl/hypergraph_indep_set_counter.sv
// Channel  Direction  Handshake               Beat contents
// in       input      in_valid_i / in_stall_o  cmd_i, edge_index_i, vertex_index_i
// out      output     out_valid_o / out_stall_i set_count_o
// cfg      input      cfg_we_i                cfg_wdata_i (vertex_count)
// An add beat does one edge-store read, then writes the merged row back.
// A count beat walks the search tree; each tree node scans all MAX_EDGES edge
// rows through the single read port.
// Only a vertex in a live edge branches; any other vertex doubles the leaf weight.
// Reset clears the edge-row valid bits at once, so no clearing pass is needed.
// A finished count waits in the output register while out_stall_i is high.
module hypergraph_indep_set_counter #(
  parameter int MAX_VERTICES = hisc_pkg::DefMaxVertices,
  parameter int MAX_EDGES    = hisc_pkg::DefMaxEdges
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hisc_pkg::VcountW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [hisc_pkg::EdgeIdxW-1:0]  edge_index_i,
  input  logic [hisc_pkg::VertIdxW-1:0]  vertex_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [hisc_pkg::CountW-1:0]    set_count_o
);
  import hisc_pkg::*;

  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int VI = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int MV = MAX_VERTICES;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLdWr = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StLeaf = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [VcountW-1:0] vcount_q;
  logic [VW-1:0]      n_q, n_d;
  logic [VW-1:0]      pos_q, pos_d;
  logic [MV-1:0]      incl_q, incl_d;
  logic [MV-1:0]      pend_q, pend_d;
  logic [MV-1:0]      free_q, free_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [EW:0]        sc_q, sc_d;
  logic               pipe_q, pipe_d;
  logic               conf_q, conf_d;
  logic               live_q, live_d;
  logic [MAX_EDGES-1:0] vld_q, vld_d;
  logic               rd_vld_q;
  logic [EW-1:0]      ld_addr_q, ld_addr_d;
  logic [VI-1:0]      ld_vert_q, ld_vert_d;
  logic               out_valid_q, out_valid_d;
  logic [CountW-1:0]  out_cnt_q, out_cnt_d;

  logic               accept;
  logic               in_range;
  logic [EW-1:0]      rd_addr;
  logic [MV-1:0]      rdata;
  logic [MV-1:0]      row;
  logic               we;
  logic [MV-1:0]      wdata;
  logic               issue;
  logic               hit;
  logic               live_row;
  logic [MV-1:0]      pos_bit;
  logic [MV-1:0]      n_mask;
  logic               bt_found;
  logic [VI-1:0]      bt_idx;
  logic [VW-1:0]      free_cnt;
  logic [VW-1:0]      n_sat;
  logic [VW-1:0]      pos_inc;

  hisc_ram #(.WIDTH(MV), .DEPTH(MAX_EDGES), .ADDR_W(EW)) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(ld_addr_q),
    .wdata_i(wdata),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  assign accept   = in_valid_i && (state_q == StIdle);
  assign in_range = (32'(edge_index_i) < MAX_EDGES) && (32'(vertex_index_i) < MV);
  assign rd_addr  = (state_q == StScan) ? sc_q[EW-1:0] : EW'(edge_index_i);
  assign row      = rd_vld_q ? rdata : '0;
  assign we       = (state_q == StLdWr);
  assign wdata    = row | (MV'(1) << ld_vert_q);
  assign issue    = (32'(sc_q) < MAX_EDGES);
  assign pos_bit  = MV'(1) << pos_q[VI-1:0];
  assign pos_inc  = pos_q + VW'(1);
  assign n_sat    = (32'(vcount_q) > MV) ? VW'(MV) : VW'(vcount_q);
  assign n_mask   = (32'(n_q) >= MV) ? '1 : ((MV'(1) << n_q) - MV'(1));

  // Including pos completes an edge when every other member is already in.
  assign hit = |(row & pos_bit) && ((row & ~pos_bit & ~incl_q) == '0);

  // An edge still constrains pos when no member lies beyond the vertex count
  // and no member below pos has been left out.
  assign live_row = |(row & pos_bit) && ((row & ~n_mask) == '0) &&
                    ((row & ~incl_q & (pos_bit - MV'(1))) == '0);

  always_comb begin
    bt_found = 1'b0;
    bt_idx   = '0;
    for (int i = 0; i < MV; i++) begin
      if (pend_q[i]) begin
        bt_found = 1'b1;
        bt_idx   = VI'(i);
      end
    end
  end

  always_comb begin
    free_cnt = '0;
    for (int i = 0; i < MV; i++) begin
      free_cnt = free_cnt + VW'(free_q[i]);
    end
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    pos_d       = pos_q;
    incl_d      = incl_q;
    pend_d      = pend_q;
    free_d      = free_q;
    cnt_d       = cnt_q;
    sc_d        = sc_q;
    pipe_d      = 1'b0;
    conf_d      = conf_q;
    live_d      = live_q;
    vld_d       = vld_q;
    ld_addr_d   = ld_addr_q;
    ld_vert_d   = ld_vert_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_cnt_d   = out_cnt_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (cmd_i == CmdAdd) begin
            ld_addr_d = EW'(edge_index_i);
            ld_vert_d = VI'(vertex_index_i);
            if (in_range) begin
              state_d = StLdWr;
            end
          end else begin
            n_d    = n_sat;
            pos_d  = '0;
            incl_d = '0;
            pend_d = '0;
            free_d = '0;
            cnt_d  = '0;
            sc_d   = '0;
            conf_d = 1'b0;
            live_d = 1'b0;
            state_d = (n_sat == '0) ? StLeaf : StScan;
          end
        end
      end
      StLdWr: begin
        vld_d[ld_addr_q] = 1'b1;
        state_d = StIdle;
      end
      StScan: begin
        if (pipe_q && hit) begin
          conf_d = 1'b1;
        end
        if (pipe_q && live_row) begin
          live_d = 1'b1;
        end
        if (issue) begin
          sc_d   = sc_q + (EW+1)'(1);
          pipe_d = 1'b1;
        end else if (!pipe_q) begin
          // Exclusion branch first; inclusion is left pending when allowed.
          // A vertex in no live edge is counted twice instead of branching.
          pend_d[pos_q[VI-1:0]] = live_q & ~conf_q;
          free_d[pos_q[VI-1:0]] = ~live_q;
          pos_d  = pos_inc;
          sc_d   = '0;
          conf_d = 1'b0;
          live_d = 1'b0;
          state_d = (pos_inc == n_q) ? StLeaf : StScan;
        end
      end
      StLeaf: begin
        cnt_d = cnt_q + (CountW'(1) << free_cnt);
        if (bt_found) begin
          pend_d[bt_idx] = 1'b0;
          incl_d = (incl_q & ((MV'(1) << bt_idx) - MV'(1))) | (MV'(1) << bt_idx);
          free_d = free_q & ((MV'(1) << bt_idx) - MV'(1));
          pos_d  = VW'(bt_idx) + VW'(1);
          sc_d   = '0;
          conf_d = 1'b0;
          live_d = 1'b0;
          state_d = ((VW'(bt_idx) + VW'(1)) == n_q) ? StLeaf : StScan;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_cnt_d   = cnt_q;
          vld_d       = '0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vcount_q    <= VcountReset;
      vld_q       <= '0;
      pipe_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      pipe_q      <= pipe_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    pos_q     <= pos_d;
    incl_q    <= incl_d;
    pend_q    <= pend_d;
    free_q    <= free_d;
    cnt_q     <= cnt_d;
    sc_q      <= sc_d;
    conf_q    <= conf_d;
    live_q    <= live_d;
    ld_addr_q <= ld_addr_d;
    ld_vert_q <= ld_vert_d;
    out_cnt_q <= out_cnt_d;
    rd_vld_q  <= vld_q[rd_addr];
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign set_count_o = out_cnt_q;

endmodule

>>> rtl/hisc_ram.sv
module hisc_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/hisc_checker.sv
module hisc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        cmd_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [32:0] set_count_o
);
  import hisc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(set_count_o))
    else $error("output beat changed while stalled");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> set_count_o != 33'd0)
    else $error("count misses the empty set");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(set_count_o[32] && (set_count_o[31:0] != 32'd0)))
    else $error("count above two to the 32");

  a_busy_after_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == CmdCount) |=> in_stall_o)
    else $error("count beat did not occupy the block");

endmodule

bind hypergraph_indep_set_counter hisc_checker u_hisc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .cmd_i      (cmd_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .set_count_o(set_count_o)
);
